// ===== design/gregorian_date_add_and_diff_defines.svh =====
// Assertion helpers shared by the date unit
`ifndef GREGORIAN_DATE_ADD_AND_DIFF_DEFINES_SVH
`define GREGORIAN_DATE_ADD_AND_DIFF_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define GDA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define GDA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gda_pkg.sv =====
`default_nettype none

package gda_pkg;

    localparam int YEAR_W = 14;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int OFF_W  = 21;
    localparam int DIFF_W = 23;

    // working serial width, signed: covers input serials plus offset
    localparam int SER_W  = 24;
    // quotient bits of a year or serial split into 400-year cycles
    localparam int Q_W    = 6;
    // year within a 400-year cycle
    localparam int R_W    = 9;
    // step counter, counts down from Q_W-1 or R_W-1
    localparam int K_W    = 4;
    // result year before truncation
    localparam int RY_W   = 15;
    // days before a year inside one cycle
    localparam int DBY_W  = 18;
    localparam int CUM_W  = 9;

    localparam int MONTHS = 12;

    localparam logic [SER_W-1:0] CYC_DAYS  = SER_W'(146097);
    localparam logic [SER_W-1:0] CYC_YEARS = SER_W'(400);

    localparam logic signed [SER_W:0] DIFF_HI = (SER_W+1)'(2**(DIFF_W-1) - 1);
    localparam logic signed [SER_W:0] DIFF_LO = (SER_W+1)'(-(2**(DIFF_W-1)));

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_DIFF = 1'b1;

    // stream packing
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 48;
    localparam int YA_LSB   = 0;
    localparam int MA_LSB   = YA_LSB + YEAR_W;
    localparam int DA_LSB   = MA_LSB + MON_W;
    localparam int OFF_LSB  = DA_LSB + DAY_W;
    localparam int YB_LSB   = OFF_LSB + OFF_W;
    localparam int MB_LSB   = YB_LSB + YEAR_W;
    localparam int DB_LSB   = MB_LSB + MON_W;
    localparam int IN_USED  = DB_LSB + DAY_W;

    localparam int RY_LSB   = 0;
    localparam int RM_LSB   = RY_LSB + YEAR_W;
    localparam int RD_LSB   = RM_LSB + MON_W;
    localparam int DIFF_LSB = RD_LSB + DAY_W;
    localparam int GT_BIT   = DIFF_LSB + DIFF_W;
    localparam int EQ_BIT   = GT_BIT + 1;

    localparam logic [DAY_W-1:0] MONTH_DAYS [MONTHS] =
        '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
    localparam logic [CUM_W-1:0] MONTH_START [MONTHS] =
        '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273,
          9'd304, 9'd334};

    typedef struct packed {
        logic                    kind;
        logic [YEAR_W-1:0]       year_a;
        logic [MON_W-1:0]        month_a;
        logic [DAY_W-1:0]        day_a;
        logic signed [OFF_W-1:0] offset;
        logic [YEAR_W-1:0]       year_b;
        logic [MON_W-1:0]        month_b;
        logic [DAY_W-1:0]        day_b;
    } t_req;

    typedef struct packed {
        logic [YEAR_W-1:0]        result_year;
        logic [MON_W-1:0]         result_month;
        logic [DAY_W-1:0]         result_day;
        logic signed [DIFF_W-1:0] days_between;
        logic                     a_greater;
        logic                     dates_equal;
        logic                     error;
    } t_res;

    function automatic logic f_valid_month(input logic [MON_W-1:0] m);
        return (m >= MON_W'(1)) && (m <= MON_W'(MONTHS));
    endfunction

    // leap rule on the year within its 400-year cycle
    function automatic logic f_leap(input logic [R_W-1:0] r);
        return (r[1:0] == 2'b00) && (r != R_W'(100)) && (r != R_W'(200)) &&
               (r != R_W'(300));
    endfunction

    // days from the start of a 400-year cycle to the start of year r
    function automatic logic [DBY_W-1:0] f_dby(input logic [R_W-1:0] r);
        logic [DBY_W-1:0] rw;
        logic [DBY_W-1:0] c100;
        rw = DBY_W'(r);
        if (r == '0) begin
            c100 = DBY_W'(0);
        end else if (r <= R_W'(100)) begin
            c100 = DBY_W'(1);
        end else if (r <= R_W'(200)) begin
            c100 = DBY_W'(2);
        end else if (r <= R_W'(300)) begin
            c100 = DBY_W'(3);
        end else begin
            c100 = DBY_W'(4);
        end
        return rw * DBY_W'(365) + ((rw + DBY_W'(3)) >> 2) - c100 +
               DBY_W'(r != '0);
    endfunction

    function automatic logic [DAY_W-1:0] f_dim(input logic [MON_W-1:0] m, input logic leap);
        logic [DAY_W-1:0] d;
        d = '0;
        if (f_valid_month(m)) begin
            d = MONTH_DAYS[m - MON_W'(1)];
            if (m == MON_W'(2) && leap) begin
                d = d + DAY_W'(1);
            end
        end
        return d;
    endfunction

    function automatic logic [CUM_W-1:0] f_cum(input logic [MON_W-1:0] m, input logic leap);
        logic [CUM_W-1:0] c;
        c = '0;
        if (f_valid_month(m)) begin
            c = MONTH_START[m - MON_W'(1)];
            if (m > MON_W'(2) && leap) begin
                c = c + CUM_W'(1);
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/gda_core.sv =====
`default_nettype none

`include "gregorian_date_add_and_diff_defines.svh"

module gda_core
    import gda_pkg::*;
#(
    parameter int unsigned YEAR_MAX = 9999
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_req i_req,
    output logic      o_ready,
    output logic      o_valid,
    output t_res      o_res,
    input  wire logic i_take
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SERH,
        ST_SERL,
        ST_ADDO,
        ST_SRCH,
        ST_YFIN,
        ST_MON,
        ST_DIFF,
        ST_DONE
    } t_state;

    t_state                   r_state;
    t_req                     r_req;
    logic                     r_phase_b;
    logic                     r_div_t;
    logic signed [SER_W-1:0]  r_acc;
    logic [Q_W-1:0]           r_q;
    logic [K_W-1:0]           r_k;
    logic [R_W-1:0]           r_r;
    logic signed [SER_W-1:0]  r_ser;
    logic signed [SER_W-1:0]  r_sa;
    logic [MON_W-1:0]         r_m;
    t_res                     r_res;

    logic signed [SER_W-1:0]  w_opb;
    logic signed [SER_W:0]    w_sub;
    logic                     w_ge;
    logic [R_W-1:0]           w_cand;
    logic                     w_cand_ok;
    logic [R_W-1:0]           w_rem;
    logic [YEAR_W-1:0]        w_year_in;
    logic [MON_W-1:0]         w_mon_in;
    logic [DAY_W-1:0]         w_day_in;
    logic                     w_in_ok;
    logic signed [SER_W-1:0]  w_serial;
    logic signed [SER_W-1:0]  w_t;
    logic [RY_W-1:0]          w_year_out;
    logic [DIFF_W-1:0]        w_diff;
    t_res                     w_err_res;

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_DONE);
    assign o_res   = r_res;

    assign w_cand    = r_r | (R_W'(1) << r_k);
    assign w_cand_ok = (w_cand < R_W'(CYC_YEARS));
    assign w_rem     = r_acc[R_W-1:0];

    // shared compare-subtract unit
    always_comb begin
        unique case (r_state)
            ST_DIV:  w_opb = r_div_t ? $signed(CYC_DAYS << r_k) : $signed(CYC_YEARS << r_k);
            ST_SRCH: w_opb = $signed(SER_W'(f_dby(w_cand)));
            ST_YFIN: w_opb = $signed(SER_W'(f_dby(r_r)));
            ST_MON:  w_opb = $signed(SER_W'(f_dim(r_m, f_leap(r_r))));
            ST_DIFF: w_opb = r_ser;
            default: w_opb = '0;
        endcase
    end

    assign w_sub = {r_acc[SER_W-1], r_acc} - {w_opb[SER_W-1], w_opb};
    assign w_ge  = !w_sub[SER_W];

    assign w_year_in = r_phase_b ? r_req.year_b  : r_req.year_a;
    assign w_mon_in  = r_phase_b ? r_req.month_b : r_req.month_a;
    assign w_day_in  = r_phase_b ? r_req.day_b   : r_req.day_a;

    assign w_in_ok = (32'(w_year_in) <= YEAR_MAX) && f_valid_month(w_mon_in) &&
                     (w_day_in != '0) && (w_day_in <= f_dim(w_mon_in, f_leap(r_r)));

    assign w_serial = r_ser + $signed(SER_W'(f_cum(w_mon_in, f_leap(r_r)))) +
                      $signed(SER_W'(w_day_in)) - SER_W'(1);

    assign w_t = r_sa + SER_W'(r_req.offset);

    assign w_year_out = RY_W'(r_q) * RY_W'(400) + RY_W'(r_r);

    always_comb begin
        if (w_sub > DIFF_HI) begin
            w_diff = DIFF_HI[DIFF_W-1:0];
        end else if (w_sub < DIFF_LO) begin
            w_diff = DIFF_LO[DIFF_W-1:0];
        end else begin
            w_diff = w_sub[DIFF_W-1:0];
        end
    end

    always_comb begin
        w_err_res       = '0;
        w_err_res.error = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_req     <= i_req;
                        r_acc     <= SER_W'(i_req.year_a);
                        r_q       <= '0;
                        r_k       <= K_W'(Q_W - 1);
                        r_phase_b <= 1'b0;
                        r_div_t   <= 1'b0;
                        r_res     <= '0;
                        r_state   <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_ge) begin
                        r_acc <= w_sub[SER_W-1:0];
                        r_q   <= r_q | (Q_W'(1) << r_k);
                    end
                    if (r_k == '0) begin
                        if (r_div_t) begin
                            r_r     <= '0;
                            r_k     <= K_W'(R_W - 1);
                            r_state <= ST_SRCH;
                        end else begin
                            r_state <= ST_SERH;
                        end
                    end else begin
                        r_k <= r_k - K_W'(1);
                    end
                end
                ST_SERH: begin
                    r_r     <= w_rem;
                    r_ser   <= $signed(SER_W'(r_q) * CYC_DAYS) + $signed(SER_W'(f_dby(w_rem)));
                    r_state <= ST_SERL;
                end
                ST_SERL: begin
                    if (!w_in_ok) begin
                        r_res   <= w_err_res;
                        r_state <= ST_DONE;
                    end else if (r_phase_b) begin
                        r_ser   <= w_serial;
                        r_acc   <= r_sa;
                        r_state <= ST_DIFF;
                    end else begin
                        r_sa <= w_serial;
                        if (r_req.kind == KIND_ADD) begin
                            r_state <= ST_ADDO;
                        end else begin
                            r_acc     <= SER_W'(r_req.year_b);
                            r_q       <= '0;
                            r_k       <= K_W'(Q_W - 1);
                            r_phase_b <= 1'b1;
                            r_state   <= ST_DIV;
                        end
                    end
                end
                ST_ADDO: begin
                    if (w_t[SER_W-1]) begin
                        r_res   <= w_err_res;
                        r_state <= ST_DONE;
                    end else begin
                        r_acc   <= w_t;
                        r_q     <= '0;
                        r_k     <= K_W'(Q_W - 1);
                        r_div_t <= 1'b1;
                        r_state <= ST_DIV;
                    end
                end
                ST_SRCH: begin
                    if (w_cand_ok && w_ge) begin
                        r_r <= w_cand;
                    end
                    if (r_k == '0) begin
                        r_state <= ST_YFIN;
                    end else begin
                        r_k <= r_k - K_W'(1);
                    end
                end
                ST_YFIN: begin
                    if (32'(w_year_out) > YEAR_MAX) begin
                        r_res   <= w_err_res;
                        r_state <= ST_DONE;
                    end else begin
                        r_acc             <= w_sub[SER_W-1:0];
                        r_res.result_year <= w_year_out[YEAR_W-1:0];
                        r_m               <= MON_W'(1);
                        r_state           <= ST_MON;
                    end
                end
                ST_MON: begin
                    if (r_m < MON_W'(MONTHS) && w_ge) begin
                        r_acc <= w_sub[SER_W-1:0];
                        r_m   <= r_m + MON_W'(1);
                    end else begin
                        r_res.result_month <= r_m;
                        r_res.result_day   <= r_acc[DAY_W-1:0] + DAY_W'(1);
                        r_state            <= ST_DONE;
                    end
                end
                ST_DIFF: begin
                    r_res.days_between <= w_diff;
                    r_res.a_greater    <= w_ge && (w_sub != '0);
                    r_res.dates_equal  <= (w_sub == '0);
                    r_state            <= ST_DONE;
                end
                ST_DONE: begin
                    if (i_take) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `GDA_ASSERT_IMP(a_mon_range, (r_state == ST_MON), (r_m >= MON_W'(1) && r_m <= MON_W'(MONTHS)), "month step out of range")
    `GDA_ASSERT_IMP(a_err_clean, (o_valid && r_res.error), (r_res.result_year == '0 && r_res.result_month == '0 && r_res.result_day == '0 && r_res.days_between == '0 && !r_res.a_greater && !r_res.dates_equal), "error result carries data")
    `GDA_ASSERT_IMP(a_add_date, (o_valid && !r_res.error && r_req.kind == KIND_ADD), (r_res.result_month != '0 && r_res.result_day != '0 && r_res.days_between == '0), "shifted date incomplete")
    `GDA_ASSERT_IMP(a_eq_flags, (o_valid && r_res.dates_equal), (!r_res.a_greater && r_res.days_between == '0), "equal dates with nonzero count")
    `GDA_ASSERT_NXT(a_start_div, (r_state == ST_IDLE && i_start), (r_state == ST_DIV && r_k == K_W'(Q_W - 1) && !r_phase_b), "start did not enter year split")

endmodule

`default_nettype wire

// ===== design/gregorian_date_add_and_diff.sv =====
// Channel  Dir  tdata  tuser  Transfer
// s_axis   in   72     1      date A, offset, date B; kind
// m_axis   out  48     1      shifted date, day count, flags; error
//
// Add: two 6-step divisions, a 9-step year search, then 1 to 12 month steps
//   on one subtractor.
// Difference: two date-to-serial passes. Early error exit on an invalid date A
//   or date B, a sum before year 0, or year overflow.
// Reset: synchronous, active low; clears sequencer and output valid.
// s_axis_tready is high only while the sequencer is idle; a finished result
//   waits in the output register while the next request runs.
`default_nettype none

module gregorian_date_add_and_diff
    import gda_pkg::*;
#(
    parameter int unsigned YEAR_MAX = 9999
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // year_a, month_a, day_a, offset, year_b, month_b, day_b, zero fill
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  wire logic [0:0]             s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // result_year, result_month, result_day, days_between, a_greater, dates_equal
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // error
    output logic [0:0]                  m_axis_tuser
);

    t_req w_req;
    t_res w_core_res;
    logic w_core_ready;
    logic w_core_valid;
    logic w_take;
    logic r_out_valid;
    t_res r_out;

    assign w_req.kind    = s_axis_tuser[0];
    assign w_req.year_a  = s_axis_tdata[YA_LSB +: YEAR_W];
    assign w_req.month_a = s_axis_tdata[MA_LSB +: MON_W];
    assign w_req.day_a   = s_axis_tdata[DA_LSB +: DAY_W];
    assign w_req.offset  = s_axis_tdata[OFF_LSB +: OFF_W];
    assign w_req.year_b  = s_axis_tdata[YB_LSB +: YEAR_W];
    assign w_req.month_b = s_axis_tdata[MB_LSB +: MON_W];
    assign w_req.day_b   = s_axis_tdata[DB_LSB +: DAY_W];

    assign s_axis_tready = w_core_ready;

    gda_core #(
        .YEAR_MAX (YEAR_MAX)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_axis_tvalid && w_core_ready),
        .i_req   (w_req),
        .o_ready (w_core_ready),
        .o_valid (w_core_valid),
        .o_res   (w_core_res),
        .i_take  (w_take)
    );

    // hand off when the output register is empty or drains this cycle
    assign w_take = w_core_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_out_valid <= 1'b1;
                r_out       <= w_core_res;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.dates_equal, r_out.a_greater, r_out.days_between,
                            r_out.result_day, r_out.result_month, r_out.result_year};
    assign m_axis_tuser  = r_out.error;

endmodule

`default_nettype wire
